### hw/rtl/tcw_pkg.sv
// Shared types and constants for the tile cache with protected-window eviction.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int WIN_W      = 16;
  localparam int SPAN_W     = 8;
  localparam int SLOT_OUT_W = 7;
  localparam int OLD_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y   = 2'd3;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 8'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_VIC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic vic_start;
    logic res_hit;
    logic res_miss;
    logic res_place;
    logic res_full;
  } cmd_t;

  typedef struct packed {
    logic fetch;
    logic issue_ok;
    logic hit;
    logic free;
    logic last;
  } status_t;

endpackage

### hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the tile tag store.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tcw_ctrl.sv
// Request sequencer: tag scan, victim scan, result hand-off.
// Depends on tcw_pkg; drives the datapath through cmd_t, reads status_t.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tcw_pkg::status_t st,
  output tcw_pkg::cmd_t    cmd
);

  tcw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tcw_pkg::ST_TAG;
      end
      tcw_pkg::ST_TAG: begin
        if (st.hit) begin
          state_nxt = tcw_pkg::ST_DONE;
        end else if (st.last) begin
          state_nxt = st.fetch ? tcw_pkg::ST_VIC : tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_VIC: begin
        if (st.free || st.last) state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (out_ready) state_nxt = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      tcw_pkg::ST_TAG: begin
        cmd.scan_step = st.issue_ok;
        if (st.hit) begin
          cmd.res_hit = 1'b1;
        end else if (st.last) begin
          cmd.vic_start = st.fetch;
          cmd.res_miss  = !st.fetch;
        end
      end
      tcw_pkg::ST_VIC: begin
        cmd.scan_step = st.issue_ok;
        if (st.free) begin
          cmd.res_place = 1'b1;
        end else if (st.last) begin
          cmd.res_full = 1'b1;
        end
      end
      tcw_pkg::ST_DONE: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/tcw_dp.sv
// Datapath: window registers, tag RAM, valid bits, scan pointers, result beat.
// Depends on tcw_pkg and tcw_ram; steered by tcw_ctrl.
`timescale 1ns / 1ps

module tcw_dp #(
  parameter int SLOTS      = 128,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_kind,
  input  logic signed [COORD_BITS-1:0]         in_tile_x,
  input  logic signed [COORD_BITS-1:0]         in_tile_y,
  input  tcw_pkg::cmd_t                        cmd,
  output tcw_pkg::status_t                     st,
  output logic                                 res_hit,
  output logic [tcw_pkg::SLOT_OUT_W-1:0]       res_slot,
  output logic                                 res_placed,
  output logic                                 res_evicted,
  output logic signed [tcw_pkg::OLD_W-1:0]     res_old_x,
  output logic signed [tcw_pkg::OLD_W-1:0]     res_old_y,
  output logic                                 res_full
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CW    = ((COORD_BITS > tcw_pkg::WIN_W) ? COORD_BITS : tcw_pkg::WIN_W) + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic signed [tcw_pkg::WIN_W-1:0] win_x_r, win_y_r;
  logic [tcw_pkg::SPAN_W-1:0]       span_x_r, span_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_x_r  <= '0;
      win_y_r  <= '0;
      span_x_r <= tcw_pkg::SPAN_RESET;
      span_y_r <= tcw_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcw_pkg::CFG_WINDOW_X: win_x_r  <= cfg_wdata;
        tcw_pkg::CFG_WINDOW_Y: win_y_r  <= cfg_wdata;
        tcw_pkg::CFG_SPAN_X:   span_x_r <= cfg_wdata[tcw_pkg::SPAN_W-1:0];
        tcw_pkg::CFG_SPAN_Y:   span_y_r <= cfg_wdata[tcw_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture
  logic                         kind_r;
  logic signed [COORD_BITS-1:0] tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= in_kind;
      tx_r   <= in_tile_x;
      ty_r   <= in_tile_y;
    end
  end

  // Scan pointers
  logic [IDX_W-1:0] rd_idx_r, cmp_idx_r, ptr_r, ptr_adv, rd_adv;
  logic [CNT_W-1:0] scan_cnt_r;
  logic             cmp_vld_r, cmp_last_r;
  logic [SLOTS-1:0] valid_r;

  assign ptr_adv = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
  assign rd_adv  = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      valid_r    <= '0;
      cmp_vld_r  <= 1'b0;
      scan_cnt_r <= '0;
      rd_idx_r   <= '0;
      cmp_idx_r  <= '0;
      cmp_last_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        rd_idx_r   <= '0;
        scan_cnt_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else if (cmd.vic_start) begin
        rd_idx_r   <= ptr_adv;
        ptr_r      <= ptr_adv;
        scan_cnt_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else begin
        cmp_vld_r <= cmd.scan_step;
        if (cmd.scan_step) begin
          rd_idx_r   <= rd_adv;
          scan_cnt_r <= scan_cnt_r + 1'b1;
          cmp_idx_r  <= rd_idx_r;
          cmp_last_r <= (scan_cnt_r == CNT_W'(SLOTS - 1));
        end
      end
      if (cmd.res_place) begin
        valid_r[cmp_idx_r] <= 1'b1;
        ptr_r              <= cmp_idx_r;
      end
    end
  end

  // Tag store
  logic [2*COORD_BITS-1:0]      rd_data;
  logic signed [COORD_BITS-1:0] rd_col, rd_row;

  tcw_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(SLOTS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (cmd.res_place),
    .waddr(cmp_idx_r),
    .wdata({tx_r, ty_r}),
    .re   (cmd.scan_step),
    .raddr(rd_idx_r),
    .rdata(rd_data)
  );

  assign rd_col = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_row = rd_data[COORD_BITS-1:0];

  // Window test, widened so the inclusive upper bound never overflows
  logic signed [CW-1:0] col_e, row_e, wx_lo, wy_lo, wx_hi, wy_hi, sx_e, sy_e;
  logic                 cmp_valid, in_window, tag_eq;

  assign col_e = CW'(rd_col);
  assign row_e = CW'(rd_row);
  assign wx_lo = CW'(win_x_r);
  assign wy_lo = CW'(win_y_r);
  assign sx_e  = {{(CW - tcw_pkg::SPAN_W){1'b0}}, span_x_r};
  assign sy_e  = {{(CW - tcw_pkg::SPAN_W){1'b0}}, span_y_r};
  assign wx_hi = wx_lo + sx_e;
  assign wy_hi = wy_lo + sy_e;

  assign in_window = (col_e >= wx_lo) && (col_e <= wx_hi) &&
                     (row_e >= wy_lo) && (row_e <= wy_hi);
  assign cmp_valid = valid_r[cmp_idx_r];
  assign tag_eq    = (rd_col == tx_r) && (rd_row == ty_r);

  assign st.fetch    = kind_r;
  assign st.issue_ok = (scan_cnt_r < CNT_W'(SLOTS));
  assign st.hit      = cmp_vld_r && cmp_valid && tag_eq;
  assign st.free     = cmp_vld_r && (!cmp_valid || !in_window);
  assign st.last     = cmp_vld_r && cmp_last_r;

  // Result beat
  always_ff @(posedge clk) begin
    if (cmd.res_hit || cmd.res_miss || cmd.res_place || cmd.res_full) begin
      res_hit     <= cmd.res_hit;
      res_slot    <= (cmd.res_hit || cmd.res_place) ?
                     tcw_pkg::SLOT_OUT_W'(cmp_idx_r) : '0;
      res_placed  <= cmd.res_place;
      res_evicted <= cmd.res_place && cmp_valid;
      res_old_x   <= (cmd.res_place && cmp_valid) ? tcw_pkg::OLD_W'(rd_col) : '0;
      res_old_y   <= (cmd.res_place && cmp_valid) ? tcw_pkg::OLD_W'(rd_row) : '0;
      res_full    <= cmd.res_full;
    end
  end

endmodule

### hw/rtl/tile_cache_window_protected_eviction.sv
// Tile cache with protected-window eviction: top level.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp (which holds tcw_ram).
//
// Usage:
//   Input beat (in_valid/in_ready): kind (0 probe, 1 fetch), tile_x, tile_y.
//   Output beat (out_valid/out_ready): hit, slot, placed, evicted, old_x,
//   old_y, full_res; exactly one output beat per input beat.
//   Config port: cfg_we with cfg_index 0 window_x, 1 window_y, 2 span_x,
//   3 span_y; write only while no request is in flight.
//   One request at a time. The tag scan reads one slot of the tag RAM per
//   cycle; a fetch miss adds a victim scan from the round-robin pointer.
//   The tag RAM has a single read port. in_ready returns the cycle after
//   the output beat.
//   Reset clears all valid bits, the pointer and the window registers
//   (origin 0, span 2). A stalled output beat holds its payload and the
//   block takes no new input until it is accepted.
`timescale 1ns / 1ps

module tile_cache_window_protected_eviction #(
  parameter int SLOTS      = 128,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic signed [COORD_BITS-1:0]      in_tile_x,
  input  logic signed [COORD_BITS-1:0]      in_tile_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [tcw_pkg::SLOT_OUT_W-1:0]    out_slot,
  output logic                              out_placed,
  output logic                              out_evicted,
  output logic signed [tcw_pkg::OLD_W-1:0]  out_old_x,
  output logic signed [tcw_pkg::OLD_W-1:0]  out_old_y,
  output logic                              out_full_res
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t st;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tcw_dp #(
    .SLOTS     (SLOTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (in_kind),
    .in_tile_x  (in_tile_x),
    .in_tile_y  (in_tile_y),
    .cmd        (cmd),
    .st         (st),
    .res_hit    (out_hit),
    .res_slot   (out_slot),
    .res_placed (out_placed),
    .res_evicted(out_evicted),
    .res_old_x  (out_old_x),
    .res_old_y  (out_old_y),
    .res_full   (out_full_res)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result beat is pending");

  a_hit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!out_placed && !out_full_res && !out_evicted))
    else $error("hit beat carries allocation flags");

  a_place_or_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_placed && out_full_res))
    else $error("beat both placed and full");

  a_evict_needs_place: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_placed) |-> (!out_evicted && out_old_x == '0 && out_old_y == '0))
    else $error("eviction reported without allocation");

endmodule

### sim/tb_tile_cache_window_protected_eviction.sv
// Self-checking testbench for tile_cache_window_protected_eviction: probes, fetches,
// round-robin eviction outside the protected window and the all-protected case.
// Depends on tcw_pkg and the RTL top level; an in-bench predictor checks every beat.
`timescale 1ns / 1ps

module tb_tile_cache_window_protected_eviction;

  localparam int NSLOTS = 128;
  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic                           hit;
    logic [tcw_pkg::SLOT_OUT_W-1:0] slot;
    logic                           placed;
    logic                           evicted;
    logic [tcw_pkg::OLD_W-1:0]      old_x;
    logic [tcw_pkg::OLD_W-1:0]      old_y;
    logic                           full_res;
  } tile_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [tcw_pkg::CFG_W-1:0]        cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             in_kind = 1'b0;
  logic signed [15:0]               in_tile_x = '0;
  logic signed [15:0]               in_tile_y = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             out_hit;
  logic [tcw_pkg::SLOT_OUT_W-1:0]   out_slot;
  logic                             out_placed;
  logic                             out_evicted;
  logic signed [tcw_pkg::OLD_W-1:0] out_old_x;
  logic signed [tcw_pkg::OLD_W-1:0] out_old_y;
  logic                             out_full_res;

  // predicted cache contents and window registers
  bit                 tag_valid [NSLOTS];
  logic signed [15:0] tag_col [NSLOTS];
  logic signed [15:0] tag_row [NSLOTS];
  int                 rr_ptr = 0;
  logic signed [15:0] win_x = '0;
  logic signed [15:0] win_y = '0;
  logic [7:0]         span_x = tcw_pkg::SPAN_RESET;
  logic [7:0]         span_y = tcw_pkg::SPAN_RESET;

  tile_result_t       pending_results[$];
  logic signed [15:0] seen_x [64];
  logic signed [15:0] seen_y [64];
  int                 seen_n = 0;
  int                 seen_wr = 0;
  int                 fail_count = 0;
  bit                 sender_steady = 1'b0;
  bit                 receiver_steady = 1'b0;

  tile_cache_window_protected_eviction dut (.*);

  always #5 clk = ~clk;

  function automatic bit in_window(logic signed [15:0] col, logic signed [15:0] row);
    int c, r, wx, wy;
    c = col;
    r = row;
    wx = win_x;
    wy = win_y;
    return c >= wx && c <= wx + int'(span_x) && r >= wy && r <= wy + int'(span_y);
  endfunction

  function automatic tile_result_t lookup_and_allocate(logic kind, logic signed [15:0] tx,
                                                       logic signed [15:0] ty);
    tile_result_t r;
    bit found;
    int i, p;
    r = '0;
    found = 1'b0;
    for (i = 0; i < NSLOTS; i++) begin
      if (!found && tag_valid[i] && tag_col[i] == tx && tag_row[i] == ty) begin
        found = 1'b1;
        r.hit = 1'b1;
        r.slot = 7'(i);
      end
    end
    if (!found && kind == KIND_FETCH) begin
      p = rr_ptr + 1;
      if (p >= NSLOTS) p = 0;
      rr_ptr = p;
      for (i = 0; i < NSLOTS; i++) begin
        if (!found && (!tag_valid[p] || !in_window(tag_col[p], tag_row[p]))) begin
          found = 1'b1;
          r.slot = 7'(p);
          r.placed = 1'b1;
          if (tag_valid[p]) begin
            r.evicted = 1'b1;
            r.old_x = tag_col[p];
            r.old_y = tag_row[p];
          end
          tag_valid[p] = 1'b1;
          tag_col[p] = tx;
          tag_row[p] = ty;
          rr_ptr = p;
        end
        if (!found) p = (p + 1) % NSLOTS;
      end
      if (!found) r.full_res = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] near_coord(logic signed [15:0] origin,
                                                    logic [7:0] span);
    int v;
    v = origin + int'($urandom_range(0, int'(span) + 6)) - 3;
    return 16'(v);
  endfunction

  task automatic send_request(input logic kind, input logic signed [15:0] tx,
                              input logic signed [15:0] ty);
    int gap;
    bit took;
    tile_result_t exp_r;
    gap = sender_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_tile_x <= tx;
    in_tile_y <= ty;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    exp_r = lookup_and_allocate(kind, tx, ty);
    pending_results = {pending_results, exp_r};
    seen_x[seen_wr] = tx;
    seen_y[seen_wr] = ty;
    seen_wr = (seen_wr + 1) % 64;
    if (seen_n < 64) seen_n++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcw_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tcw_pkg::CFG_WINDOW_X: win_x = data;
      tcw_pkg::CFG_WINDOW_Y: win_y = data;
      tcw_pkg::CFG_SPAN_X:   span_x = data[7:0];
      tcw_pkg::CFG_SPAN_Y:   span_y = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input logic signed [15:0] wx, input logic signed [15:0] wy,
                            input logic [7:0] sx, input logic [7:0] sy);
    drain();
    write_reg(tcw_pkg::CFG_WINDOW_X, wx);
    write_reg(tcw_pkg::CFG_WINDOW_Y, wy);
    write_reg(tcw_pkg::CFG_SPAN_X, {8'($urandom), sx});
    write_reg(tcw_pkg::CFG_SPAN_Y, {8'($urandom), sy});
  endtask

  task automatic check_beat();
    tile_result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("[%0t] result beat with no request pending", $time);
    end else begin
      want = pending_results.pop_front();
      if (out_hit !== want.hit || out_slot !== want.slot || out_placed !== want.placed ||
          out_evicted !== want.evicted || out_old_x !== want.old_x ||
          out_old_y !== want.old_y || out_full_res !== want.full_res) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display({"[%0t] mismatch exp hit=%0d slot=%0d placed=%0d evicted=%0d",
                    " old=(%0d,%0d) full=%0d"},
                   $time, want.hit, want.slot, want.placed, want.evicted,
                   $signed(want.old_x), $signed(want.old_y), want.full_res);
          $display({"[%0t]          got hit=%0d slot=%0d placed=%0d evicted=%0d",
                    " old=(%0d,%0d) full=%0d"},
                   $time, out_hit, out_slot, out_placed, out_evicted,
                   out_old_x, out_old_y, out_full_res);
        end
      end
    end
  endtask

  // result side: check at the falling edge, pace ready at the rising edge
  initial begin : result_side
    int wait_left;
    logic ready_next;
    wait_left = 0;
    forever begin
      @(negedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        check_beat();
        wait_left = receiver_steady ? 0 : $urandom_range(0, 12);
        ready_next = (wait_left == 0);
      end else if (wait_left > 0) begin
        if (out_valid === 1'b1) wait_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      @(posedge clk);
      out_ready <= ready_next;
    end
  end

  task automatic test_directed_basics();
    send_request(KIND_PROBE, 16'h0000, 16'h0000);
    send_request(KIND_FETCH, 16'h8000, 16'h7FFF);
    send_request(KIND_PROBE, 16'h8000, 16'h7FFF);
    send_request(KIND_FETCH, 16'h8000, 16'h7FFF);
    send_request(KIND_FETCH, 16'h7FFF, 16'h8000);
    send_request(KIND_FETCH, 16'h0000, 16'h0000);
    send_request(KIND_FETCH, 16'h0002, 16'h0002);
    send_request(KIND_FETCH, 16'hFFFF, 16'hFFFF);
    send_request(KIND_FETCH, 16'h5555, 16'hAAAA);
    send_request(KIND_PROBE, 16'hAAAA, 16'h5555);
    send_request(KIND_PROBE, 16'h0002, 16'h0002);
    send_request(KIND_FETCH, 16'h0000, 16'h0000);
  endtask

  task automatic test_config_extremes();
    set_window(16'h8000, 16'h7FFF, 8'd255, 8'd0);
    send_request(KIND_FETCH, 16'h80FF, 16'h7FFF);
    send_request(KIND_FETCH, 16'h8100, 16'h7FFF);
    send_request(KIND_PROBE, 16'h8000, 16'h7FFF);
    send_request(KIND_FETCH, 16'h8000, 16'h7FFE);
    set_window(16'h7FFF, 16'h8000, 8'd0, 8'd255);
    send_request(KIND_FETCH, 16'h7FFF, 16'h80FF);
    send_request(KIND_FETCH, 16'h7FFF, 16'h8000);
    send_request(KIND_PROBE, 16'h7FFE, 16'h8000);
  endtask

  // a 16 x 8 window holds exactly as many tiles as there are slots
  task automatic test_full_window();
    logic signed [15:0] wx, wy;
    int k, idx, stride, offset;
    wx = 16'(int'($urandom_range(0, 65520)) - 32768);
    wy = 16'(int'($urandom_range(0, 65528)) - 32768);
    stride = 2 * $urandom_range(0, 63) + 1;
    offset = $urandom_range(0, 127);
    set_window(wx, wy, 8'd15, 8'd7);
    for (k = 0; k < NSLOTS; k++) begin
      idx = (k * stride + offset) % NSLOTS;
      send_request(KIND_FETCH, wx + 16'(idx % 16), wy + 16'(idx / 16));
    end
    for (k = 0; k < 12; k++) begin
      idx = $urandom_range(0, 127);
      case (k % 3)
        0: send_request(KIND_PROBE, wx + 16'(idx % 16), wy + 16'(idx / 16));
        1: send_request(KIND_FETCH, (k % 2) ? wx - 16'sd1 : wx + 16'sd16, wy + 16'(idx % 8));
        default: send_request(KIND_FETCH, wx + 16'(idx % 16), wy + 16'(idx / 16));
      endcase
    end
  endtask

  task automatic test_random_phases();
    logic signed [15:0] wx, wy, tx, ty;
    logic [7:0] sx, sy;
    logic kind;
    int phase, k, pick, j;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin wx = 16'h7FFF; wy = 16'h8000; sx = 8'd255; sy = 8'd0; end
        1: begin wx = 16'h8000; wy = 16'h7FFF; sx = 8'd0; sy = 8'd255; end
        2: begin wx = 16'($urandom); wy = 16'($urandom); sx = 8'd255; sy = 8'd255; end
        3: begin wx = 16'($urandom); wy = 16'($urandom); sx = 8'd0; sy = 8'd0; end
        default: begin
          wx = 16'($urandom);
          wy = 16'($urandom);
          sx = 8'($urandom);
          sy = 8'($urandom);
        end
      endcase
      set_window(wx, wy, sx, sy);
      sender_steady = (phase == 1 || phase == 5);
      receiver_steady = (phase == 2 || phase == 5);
      for (k = 0; k < 150; k++) begin
        if (k == 75) drain();
        kind = ($urandom_range(0, 9) < 7) ? KIND_FETCH : KIND_PROBE;
        pick = $urandom_range(0, 99);
        if (pick < 55 || seen_n == 0) begin
          tx = near_coord(wx, sx);
          ty = near_coord(wy, sy);
        end else if (pick < 80) begin
          j = $urandom_range(0, seen_n - 1);
          tx = seen_x[j];
          ty = seen_y[j];
        end else begin
          tx = 16'($urandom);
          ty = 16'($urandom);
        end
        send_request(kind, tx, ty);
      end
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_config_extremes();
    test_full_window();
    test_random_phases();
    drain();
    repeat (300) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb_tile_cache_window_protected_eviction passed");
    end else begin
      $display("tb_tile_cache_window_protected_eviction failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_tile_cache_window_protected_eviction failed");
    $finish;
  end

endmodule
